// ===== hdl/tricorn_julia_escape_time_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Tricorn Julia escape-time unit: assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TRICORN_JULIA_ESCAPE_TIME_UNIT_ASSERT_SVH
`define TRICORN_JULIA_ESCAPE_TIME_UNIT_ASSERT_SVH

// same-cycle implication
`define TJE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tje: same-cycle check failed");

// next-cycle implication
`define TJE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tje: next-cycle check failed");

`endif

// ===== hdl/tje_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tricorn Julia escape-time unit: package
// Widths, register indexes, reset values and sequencer control types.
// ----------------------------------------------------------------------------
package tje_pkg;

	localparam int DATA_W  = 32;
	localparam int OUT_W   = 18;
	localparam int ITER_W  = 16;
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_LAMBDA_REAL    = 2'd0;
	localparam logic [IDX_W-1:0] REG_LAMBDA_IMAG    = 2'd1;
	localparam logic [IDX_W-1:0] REG_MAX_ITERATIONS = 2'd2;

	localparam logic signed [DATA_W-1:0] LAMBDA_REAL_RST = -32'sd67108864;
	localparam logic signed [DATA_W-1:0] LAMBDA_IMAG_RST = 32'sd0;
	localparam logic [ITER_W-1:0]        MAX_ITER_RST    = 16'd100;

	typedef enum logic [2:0] {
		OP_RE_RE = 3'd0,
		OP_IM_IM = 3'd1,
		OP_LR_RE = 3'd2,
		OP_LI_IM = 3'd3,
		OP_LI_RE = 3'd4,
		OP_LR_IM = 3'd5,
		OP_RE_IM = 3'd6
	} op_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD       = 3'd0,
		ACC_LOAD_RE    = 3'd1,
		ACC_ADD_RE     = 3'd2,
		ACC_SUB_RE     = 3'd3,
		ACC_LOAD_IM    = 3'd4,
		ACC_SUB_IM     = 3'd5,
		ACC_SUB_IM_DBL = 3'd6
	} acc_op_t;

	typedef struct packed {
		logic    load;
		op_sel_t op_sel;
		acc_op_t acc_op;
		logic    save_rr;
		logic    commit;
	} ctl_t;

endpackage

// ===== hdl/tje_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tricorn Julia escape-time unit: shared multiplier
// Signed 32x32 multiply with a registered 64-bit product.
// ----------------------------------------------------------------------------
module tje_mult (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] prod
);

	logic signed [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

// ===== hdl/tje_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tricorn Julia escape-time unit: sequencer
// Steps the shared multiplier through each iteration, counts iterations and
// forms the escape value.
// ----------------------------------------------------------------------------
module tje_ctrl #(
	parameter int COUNT_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_fire,
	input  logic [tje_pkg::ITER_W-1:0] max_iterations,
	input  logic                     escape,
	input  logic                     out_free,
	output logic                     busy,
	output tje_pkg::ctl_t            ctl,
	output logic                     fin,
	output logic [tje_pkg::OUT_W-1:0] result
);
	import tje_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_RUN    = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	localparam logic [32:0] CAP = (33'd1 << COUNT_BITS) - 33'd1;

	state_t                state_q;
	logic [2:0]            step_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] limit_q;
	logic [COUNT_BITS-1:0] limit_d;
	logic [32:0]           limit_wide;
	logic [COUNT_BITS:0]   cnt_dbl;
	logic [OUT_W-1:0]      res_q;
	logic                  hit_limit;
	logic                  hit_escape;

	assign limit_wide = 33'(max_iterations);
	assign limit_d    = (limit_wide > CAP) ? COUNT_BITS'(CAP) : COUNT_BITS'(limit_wide);
	assign cnt_dbl    = {cnt_q, 1'b0};

	assign hit_limit  = (state_q == S_RUN) && (step_q == 3'd0) && (cnt_q == limit_q);
	assign hit_escape = (state_q == S_RUN) && (step_q == 3'd2) && escape;

	always_comb begin
		ctl         = '0;
		ctl.load    = in_fire;
		ctl.op_sel  = OP_RE_RE;
		ctl.acc_op  = ACC_HOLD;
		if (state_q == S_RUN) begin
			unique case (step_q)
				3'd0: ctl.op_sel = OP_RE_RE;
				3'd1: begin
					ctl.op_sel  = OP_IM_IM;
					ctl.acc_op  = ACC_LOAD_RE;
					ctl.save_rr = 1'b1;
				end
				3'd2: begin
					ctl.op_sel = OP_LR_RE;
					ctl.acc_op = ACC_SUB_RE;
				end
				3'd3: begin
					ctl.op_sel = OP_LI_IM;
					ctl.acc_op = ACC_ADD_RE;
				end
				3'd4: begin
					ctl.op_sel = OP_LI_RE;
					ctl.acc_op = ACC_ADD_RE;
				end
				3'd5: begin
					ctl.op_sel = OP_LR_IM;
					ctl.acc_op = ACC_LOAD_IM;
				end
				3'd6: begin
					ctl.op_sel = OP_RE_IM;
					ctl.acc_op = ACC_SUB_IM;
				end
				3'd7: begin
					ctl.acc_op = ACC_SUB_IM_DBL;
					ctl.commit = 1'b1;
				end
				default: ctl.acc_op = ACC_HOLD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			cnt_q   <= '0;
			limit_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_RUN;
						step_q  <= '0;
						cnt_q   <= '0;
						limit_q <= limit_d;
					end
				end
				S_RUN: begin
					if (hit_limit || hit_escape) begin
						state_q <= S_FINISH;
					end else begin
						step_q <= step_q + 3'd1;
						if (ctl.commit) begin
							cnt_q <= cnt_q + COUNT_BITS'(1);
						end
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hit_limit) begin
			res_q <= '1;
		end else if (hit_escape) begin
			res_q <= OUT_W'(cnt_dbl);
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign fin    = (state_q == S_FINISH) && out_free;
	assign result = res_q;

endmodule

// ===== hdl/tricorn_julia_escape_time_unit.sv =====
`timescale 1ns / 1ps
// Points are taken one at a time; each iteration is paced by the one shared
// 32x32 multiplier forming seven products per iteration.
// Reset: registers return to lambda = -1.0 + 0i and a limit of 100, idle.
// ----------------------------------------------------------------------------
// Tricorn Julia escape-time unit: top level
// Iterates z -> lambda*conj(z) + conj(z^2) on one shared multiplier and
// returns twice the escape count, or -1 for a bounded point.
// ----------------------------------------------------------------------------
module tricorn_julia_escape_time_unit #(
	parameter int FRAC_BITS  = 26,
	parameter int COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tje_pkg::IDX_W-1:0]         cfg_index,
	input  logic [tje_pkg::DATA_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [tje_pkg::DATA_W-1:0] start_real,
	input  logic signed [tje_pkg::DATA_W-1:0] start_imag,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [tje_pkg::OUT_W-1:0]  escape_value
);
	import tje_pkg::*;

	localparam int ACC_W = (67 - FRAC_BITS > 33) ? (67 - FRAC_BITS) : 33;
	localparam logic [64:0] MAG_LIMIT = 65'd10 << FRAC_BITS;
	localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-32){1'b0}}, 32'h7fffffff};
	localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-32){1'b1}}, 32'h80000000};

	logic signed [DATA_W-1:0] lambda_real_q;
	logic signed [DATA_W-1:0] lambda_imag_q;
	logic [ITER_W-1:0]        max_iter_q;

	logic signed [DATA_W-1:0] re_q;
	logic signed [DATA_W-1:0] im_q;
	logic signed [63:0]       rr_q;
	logic signed [ACC_W-1:0]  acc_re_q;
	logic signed [ACC_W-1:0]  acc_im_q;
	logic signed [OUT_W-1:0]  escape_value_q;
	logic                     out_valid_q;

	logic                     in_fire;
	logic                     out_free;
	logic                     busy;
	logic                     fin;
	logic                     escape;
	logic [OUT_W-1:0]         result;
	ctl_t                     ctl;

	logic signed [DATA_W-1:0] op_a;
	logic signed [DATA_W-1:0] op_b;
	logic signed [63:0]       prod;
	logic signed [63:0]       sh_one;
	logic signed [63:0]       sh_dbl;
	logic signed [ACC_W-1:0]  term_one;
	logic signed [ACC_W-1:0]  term_dbl;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  sum;
	logic                     neg;
	logic [64:0]              mag_sum;
	logic [64:0]              mag;

	function automatic logic signed [31:0] sat_word(input logic signed [ACC_W-1:0] x);
		logic signed [31:0] r;
		if (x > SAT_HI) begin
			r = 32'sh7fffffff;
		end else if (x < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_real_q <= LAMBDA_REAL_RST;
			lambda_imag_q <= LAMBDA_IMAG_RST;
			max_iter_q    <= MAX_ITER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LAMBDA_REAL:    lambda_real_q <= cfg_data;
				REG_LAMBDA_IMAG:    lambda_imag_q <= cfg_data;
				REG_MAX_ITERATIONS: max_iter_q    <= cfg_data[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	tje_ctrl #(
		.COUNT_BITS(COUNT_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (in_fire),
		.max_iterations(max_iter_q),
		.escape        (escape),
		.out_free      (out_free),
		.busy          (busy),
		.ctl           (ctl),
		.fin           (fin),
		.result        (result)
	);

	always_comb begin
		unique case (ctl.op_sel)
			OP_RE_RE: begin op_a = re_q;          op_b = re_q; end
			OP_IM_IM: begin op_a = im_q;          op_b = im_q; end
			OP_LR_RE: begin op_a = lambda_real_q; op_b = re_q; end
			OP_LI_IM: begin op_a = lambda_imag_q; op_b = im_q; end
			OP_LI_RE: begin op_a = lambda_imag_q; op_b = re_q; end
			OP_LR_IM: begin op_a = lambda_real_q; op_b = im_q; end
			OP_RE_IM: begin op_a = re_q;          op_b = im_q; end
			default:  begin op_a = re_q;          op_b = im_q; end
		endcase
	end

	tje_mult u_mult (
		.clk (clk),
		.a   (op_a),
		.b   (op_b),
		.prod(prod)
	);

	assign sh_one   = prod >>> FRAC_BITS;
	assign sh_dbl   = prod >>> (FRAC_BITS - 1);
	assign term_one = ACC_W'(sh_one);
	assign term_dbl = ACC_W'(sh_dbl);

	// squares are never negative: sum them as unsigned
	assign mag_sum = {1'b0, rr_q} + {1'b0, prod};
	assign mag     = mag_sum >> FRAC_BITS;
	assign escape  = (mag >= MAG_LIMIT);

	always_comb begin
		base   = '0;
		addend = term_one;
		neg    = 1'b0;
		unique case (ctl.acc_op)
			ACC_HOLD:    ;
			ACC_LOAD_RE: ;
			ACC_ADD_RE:  base = acc_re_q;
			ACC_SUB_RE: begin
				base = acc_re_q;
				neg  = 1'b1;
			end
			ACC_LOAD_IM: ;
			ACC_SUB_IM: begin
				base = acc_im_q;
				neg  = 1'b1;
			end
			ACC_SUB_IM_DBL: begin
				base   = acc_im_q;
				addend = term_dbl;
				neg    = 1'b1;
			end
			default: ;
		endcase
		sum = neg ? (base - addend) : (base + addend);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			re_q <= start_real;
			im_q <= start_imag;
		end else if (ctl.commit) begin
			re_q <= sat_word(acc_re_q);
			im_q <= sat_word(sum);
		end
		if (ctl.save_rr) begin
			rr_q <= prod;
		end
		if (ctl.acc_op == ACC_LOAD_RE || ctl.acc_op == ACC_ADD_RE ||
		    ctl.acc_op == ACC_SUB_RE) begin
			acc_re_q <= sum;
		end
		if (ctl.acc_op == ACC_LOAD_IM || ctl.acc_op == ACC_SUB_IM) begin
			acc_im_q <= sum;
		end
		if (fin) begin
			escape_value_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign escape_value = escape_value_q;

endmodule

// ===== hdl/tje_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tricorn Julia escape-time unit: port checker
// Watches the channel ports of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
`include "tricorn_julia_escape_time_unit_assert.svh"

module tje_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [tje_pkg::OUT_W-1:0] escape_value
);

	`TJE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(escape_value))
	`TJE_ASSERT_IMPLY(a_out_code, clk, arst_n, out_valid, (&escape_value) || !escape_value[0])
	`TJE_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, in_valid && !in_stall, in_stall)
	`TJE_ASSERT_NEXT(a_no_early_result, clk, arst_n, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind tricorn_julia_escape_time_unit tje_chk u_chk (.*);
